// ===== src/tracked_target_select_core_assert.svh =====
// ---------------------------------------------------------------------------
// tracked target select assertion macros
// concurrent checks on aclk, off while aresetn is low, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef TRACKED_TARGET_SELECT_CORE_ASSERT_SVH
`define TRACKED_TARGET_SELECT_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// expression holds at every edge
`define TTSEL_ASSERT(name, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// consequent holds at the edge after the antecedent
`define TTSEL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TTSEL_ASSERT(name, expr, msg)
`define TTSEL_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== src/ttsel_pkg.sv =====
// ---------------------------------------------------------------------------
// ttsel_pkg
// shared widths, parameter defaults, sequencer states and status type of the target selector
// ---------------------------------------------------------------------------
package ttsel_pkg;

    localparam int AREA_W     = 24;
    localparam int COORD_W    = 16;
    localparam int INDEX_W    = 6;
    localparam int WEIGHT_W   = 8;
    localparam int RAD_W      = 33;
    localparam int ROOT_W     = 17;
    localparam int MUL_W      = 17;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int PEN_W      = WEIGHT_W + ROOT_W;
    localparam int SCORE_W    = 30;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 40;

    localparam int MAX_BOXES_DEF       = 64;
    localparam int DISTANCE_WEIGHT_DEF = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ROOT,
        ST_WEIGHT,
        ST_CMP,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

endpackage

// ===== src/tracked_target_select_core.sv =====
// ---------------------------------------------------------------------------
// tracked_target_select_core
// picks one target box per frame from distance-weighted area scores
// ---------------------------------------------------------------------------
// boxes of one frame arrive on the s_ channel, one word each, tlast on the
// last box. per box the sequencer runs dx*dx and dy*dy through one shared
// multiplier, a 17-step iterative square root, the weight multiply and a
// compare against the leading score, and s_tready stays low until that
// compare is done. after a tlast box an emit step loads the winner into
// the m_ output register (index and centre of the first strictly highest
// score), which also becomes the previous target. boxes past MAX_BOXES in a
// frame are accepted and dropped. the output register lets the next frame
// start while the result waits; if m_tready is low when the following
// winner is ready, the sequencer holds in its emit step until the word is
// taken. reset clears the previous target centre to the origin, the box
// count and the output valid; there is no clearing pass.
// ---------------------------------------------------------------------------
`include "tracked_target_select_core_assert.svh"

module tracked_target_select_core #(
    parameter int MAX_BOXES       = ttsel_pkg::MAX_BOXES_DEF,
    parameter int DISTANCE_WEIGHT = ttsel_pkg::DISTANCE_WEIGHT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // box_area[23:0], center_x[39:24], center_y[55:40]
    input  logic [ttsel_pkg::S_DATA_W-1:0] s_tdata,
    // frame_end
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // winner_index[5:0], winner_x[21:6], winner_y[37:22], zero[39:38]
    output logic [ttsel_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int CNT_W   = $clog2(MAX_BOXES + 1);
    localparam int IDX_W   = $clog2(MAX_BOXES);
    localparam int AREA_W  = ttsel_pkg::AREA_W;
    localparam int COORD_W = ttsel_pkg::COORD_W;
    localparam int MUL_W   = ttsel_pkg::MUL_W;
    localparam int PROD_W  = ttsel_pkg::PROD_W;
    localparam int RAD_W   = ttsel_pkg::RAD_W;
    localparam int ROOT_W  = ttsel_pkg::ROOT_W;
    localparam int PEN_W   = ttsel_pkg::PEN_W;
    localparam int SCORE_W = ttsel_pkg::SCORE_W;
    localparam int M_PAD_W = ttsel_pkg::M_DATA_W - ttsel_pkg::INDEX_W - 2 * COORD_W;

    ttsel_pkg::seq_state_t state_reg, state_next;

    logic [AREA_W-1:0]  area_reg;
    logic [COORD_W-1:0] cx_reg, cy_reg;
    logic               last_reg;
    logic [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic [CNT_W-1:0]   seen_reg, seen_next;
    logic signed [SCORE_W-1:0] lead_score_reg;
    logic [IDX_W-1:0]   lead_idx_reg;
    logic [COORD_W-1:0] lead_x_reg, lead_y_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [PEN_W-1:0]   pen_reg;

    logic                        m_valid_reg;
    logic [ttsel_pkg::INDEX_W-1:0] win_idx_reg;
    logic [COORD_W-1:0]          win_x_reg, win_y_reg;

    logic [COORD_W-1:0] dx, dy;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  prod;
    logic               sq_start;
    logic [RAD_W-1:0]   sq_rad;
    logic [ROOT_W-1:0]  sq_root;
    ttsel_pkg::sqrt_stat_t sq_stat;
    logic signed [SCORE_W-1:0] score;
    logic               take_lead;
    logic               out_free;
    logic               accept;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign dx = (cx_reg >= prev_x_reg) ? cx_reg - prev_x_reg : prev_x_reg - cx_reg;
    assign dy = (cy_reg >= prev_y_reg) ? cy_reg - prev_y_reg : prev_y_reg - cy_reg;

    // shared multiplier
    always_comb begin
        mul_a = MUL_W'(dx);
        mul_b = MUL_W'(dx);
        case (state_reg)
            ttsel_pkg::ST_SQ_Y: begin
                mul_a = MUL_W'(dy);
                mul_b = MUL_W'(dy);
            end
            ttsel_pkg::ST_WEIGHT: begin
                mul_a = MUL_W'(DISTANCE_WEIGHT);
                mul_b = MUL_W'(sq_root);
            end
            default: begin
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign sq_rad = rad_reg + prod[RAD_W-1:0];

    assign score = $signed({2'b00, area_reg, 4'b0000})
                 - $signed({{(SCORE_W-PEN_W){1'b0}}, pen_reg});
    assign take_lead = (seen_reg == '0) || (score > lead_score_reg);

    ttsel_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_rad),
        .root     (sq_root),
        .stat     (sq_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ttsel_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        sq_start   = 1'b0;
        seen_next  = seen_reg;
        case (state_reg)
            ttsel_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (seen_reg < CNT_W'(MAX_BOXES)) begin
                        state_next = ttsel_pkg::ST_SQ_X;
                    end else if (s_tlast) begin
                        state_next = ttsel_pkg::ST_EMIT;
                    end
                end
            end
            ttsel_pkg::ST_SQ_X: begin
                state_next = ttsel_pkg::ST_SQ_Y;
            end
            ttsel_pkg::ST_SQ_Y: begin
                sq_start   = 1'b1;
                state_next = ttsel_pkg::ST_ROOT;
            end
            ttsel_pkg::ST_ROOT: begin
                if (sq_stat.done) begin
                    state_next = ttsel_pkg::ST_WEIGHT;
                end
            end
            ttsel_pkg::ST_WEIGHT: begin
                state_next = ttsel_pkg::ST_CMP;
            end
            ttsel_pkg::ST_CMP: begin
                seen_next  = seen_reg + 1'b1;
                state_next = last_reg ? ttsel_pkg::ST_EMIT : ttsel_pkg::ST_IDLE;
            end
            ttsel_pkg::ST_EMIT: begin
                if (out_free) begin
                    seen_next  = '0;
                    state_next = ttsel_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ttsel_pkg::ST_IDLE;
            end
        endcase
    end

    // control and model state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg       <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            lead_score_reg <= '0;
            lead_idx_reg   <= '0;
            lead_x_reg     <= '0;
            lead_y_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            seen_reg <= seen_next;
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ttsel_pkg::ST_CMP && take_lead) begin
                lead_score_reg <= score;
                lead_idx_reg   <= seen_reg[IDX_W-1:0];
                lead_x_reg     <= cx_reg;
                lead_y_reg     <= cy_reg;
            end
            if (state_reg == ttsel_pkg::ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
                prev_x_reg  <= lead_x_reg;
                prev_y_reg  <= lead_y_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            area_reg <= s_tdata[AREA_W-1:0];
            cx_reg   <= s_tdata[AREA_W +: COORD_W];
            cy_reg   <= s_tdata[AREA_W+COORD_W +: COORD_W];
            last_reg <= s_tlast;
        end
        if (state_reg == ttsel_pkg::ST_SQ_X) begin
            rad_reg <= prod[RAD_W-1:0];
        end
        if (state_reg == ttsel_pkg::ST_WEIGHT) begin
            pen_reg <= prod[PEN_W-1:0];
        end
        if (state_reg == ttsel_pkg::ST_EMIT && out_free) begin
            win_idx_reg <= ttsel_pkg::INDEX_W'(lead_idx_reg);
            win_x_reg   <= lead_x_reg;
            win_y_reg   <= lead_y_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, win_y_reg, win_x_reg, win_idx_reg};

    `TTSEL_ASSERT(a_done_in_root, !sq_stat.done || state_reg == ttsel_pkg::ST_ROOT,
        "square root finished outside root step")
    `TTSEL_ASSERT(a_seen_bound, seen_reg <= CNT_W'(MAX_BOXES), "box count past limit")
    `TTSEL_ASSERT_NEXT(a_cmp_counts, state_reg == ttsel_pkg::ST_CMP, seen_reg != '0,
        "scored box not counted")
    `TTSEL_ASSERT_NEXT(a_emit_prev, state_reg == ttsel_pkg::ST_EMIT && out_free,
        m_valid_reg && prev_x_reg == win_x_reg && prev_y_reg == win_y_reg,
        "previous target differs from emitted winner")

endmodule

// ===== src/ttsel_isqrt.sv =====
// ---------------------------------------------------------------------------
// ttsel_isqrt
// iterative truncated square root, two radicand bits per cycle
// ---------------------------------------------------------------------------
`include "tracked_target_select_core_assert.svh"

module ttsel_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ttsel_pkg::RAD_W-1:0] radicand,
    output logic [ttsel_pkg::ROOT_W-1:0] root,
    output ttsel_pkg::sqrt_stat_t       stat
);

    localparam int RAD_W = ttsel_pkg::RAD_W;
    localparam int ACC_W = RAD_W + 1;

    logic             busy_reg;
    logic             done_reg;
    logic [RAD_W-1:0] rem_reg;
    logic [ACC_W-1:0] root_reg;
    logic [RAD_W-1:0] bit_reg;
    logic [ACC_W-1:0] trial;
    logic             fits;

    assign trial = root_reg + {1'b0, bit_reg};
    assign fits  = ({1'b0, rem_reg} >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= radicand;
            root_reg <= '0;
            bit_reg  <= {1'b1, {(RAD_W-1){1'b0}}};
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg  <= rem_reg - trial[RAD_W-1:0];
                root_reg <= (root_reg >> 1) + {1'b0, bit_reg};
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root      = root_reg[ttsel_pkg::ROOT_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `TTSEL_ASSERT(a_start_idle, !(start && busy_reg), "sqrt started while busy")
    `TTSEL_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "sqrt done held")
    `TTSEL_ASSERT_NEXT(a_start_busy, start, busy_reg && !done_reg, "sqrt did not start")

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// tracked_target_select_core testbench
// frames of candidate boxes go in on the s_ stream, one word per box, tlast
// on the closing box. a predictor of the distance-weighted area score keeps
// its own previous target and leader and queues the winner of every closed
// frame; each m_ word is checked against the oldest queued winner. the
// sender works in random bursts and gaps, the receiver stalls on a pattern
// of its own, and a watchdog ends a run that stops moving.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AREA_W       = ttsel_pkg::AREA_W;
    localparam int COORD_W      = ttsel_pkg::COORD_W;
    localparam int INDEX_W      = ttsel_pkg::INDEX_W;
    localparam int S_DATA_W     = ttsel_pkg::S_DATA_W;
    localparam int M_DATA_W     = ttsel_pkg::M_DATA_W;
    localparam int FRAME_CAP    = ttsel_pkg::MAX_BOXES_DEF;
    localparam int WEIGHT       = ttsel_pkg::DISTANCE_WEIGHT_DEF;
    localparam int RANDOM_BOXES = 1100;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 60;
    localparam logic [AREA_W-1:0]  AREA_MAX  = '1;
    localparam logic [COORD_W-1:0] COORD_MAX = '1;

    typedef struct {
        logic [AREA_W-1:0]  area;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic               last;
        bit                 drain_first;
    } box_t;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } pick_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // box_area[23:0], center_x[39:24], center_y[55:40]
    logic [S_DATA_W-1:0] s_tdata  = '0;
    // frame_end
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // winner_index[5:0], winner_x[21:6], winner_y[37:22], zero[39:38]
    logic [M_DATA_W-1:0] m_tdata;

    box_t  box_q[$];
    pick_t picks_q[$];
    box_t  on_bus;

    logic [COORD_W-1:0] prior_x   = '0;
    logic [COORD_W-1:0] prior_y   = '0;
    longint             lead_score = 0;
    int                 lead_slot  = 0;
    logic [COORD_W-1:0] lead_x    = '0;
    logic [COORD_W-1:0] lead_y    = '0;
    int                 taken     = 0;

    int mismatch_count = 0;
    int burst_left     = 1;
    int gap_left       = 0;
    int ready_run      = 0;
    int stall_run      = 0;
    int idle_cycles    = 0;

    tracked_target_select_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // truncated square root by binary search
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd1 << 17;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic void predict_box(box_t b);
        longint unsigned dx;
        longint unsigned dy;
        longint          area_l;
        longint          score;
        pick_t           p;
        if (taken < FRAME_CAP) begin
            dx = (b.cx >= prior_x) ? 64'(b.cx - prior_x) : 64'(prior_x - b.cx);
            dy = (b.cy >= prior_y) ? 64'(b.cy - prior_y) : 64'(prior_y - b.cy);
            area_l = longint'(b.area);
            score = area_l * 16 - WEIGHT * longint'(floor_root(dx * dx + dy * dy));
            if (taken == 0 || score > lead_score) begin
                lead_score = score;
                lead_slot  = taken;
                lead_x     = b.cx;
                lead_y     = b.cy;
            end
            taken++;
        end
        if (b.last) begin
            p.index = lead_slot[INDEX_W-1:0];
            p.x     = lead_x;
            p.y     = lead_y;
            picks_q.push_back(p);
            prior_x = lead_x;
            prior_y = lead_y;
            taken   = 0;
        end
    endfunction

    task automatic add_box(logic [AREA_W-1:0] area, logic [COORD_W-1:0] cx,
                           logic [COORD_W-1:0] cy, logic last, bit drain_first);
        box_t b;
        b.area        = area;
        b.cx          = cx;
        b.cy          = cy;
        b.last        = last;
        b.drain_first = drain_first;
        box_q.push_back(b);
    endtask

    task automatic note_mismatch(string field, longint unsigned want, longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, field, want, got);
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tlast  <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                predict_box(on_bus);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (box_q.size() > 0 &&
                             !(box_q[0].drain_first && (picks_q.size() > 0 || m_tvalid))) begin
                    on_bus = box_q.pop_front();
                    s_tdata  <= {on_bus.cy, on_bus.cx, on_bus.area};
                    s_tlast  <= on_bus.last;
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (ready_run > 0) begin
            ready_run--;
            m_tready <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
            m_tready <= 1'b0;
        end else begin
            ready_run = $urandom_range(1, 60);
            stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        pick_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (picks_q.size() == 0) begin
                note_mismatch("unexpected result word", 64'd0, 64'(m_tdata));
            end else begin
                want = picks_q.pop_front();
                if (m_tdata[INDEX_W-1:0] !== want.index)
                    note_mismatch("winner_index", 64'(want.index),
                                  64'(m_tdata[INDEX_W-1:0]));
                if (m_tdata[INDEX_W +: COORD_W] !== want.x)
                    note_mismatch("winner_x", 64'(want.x), 64'(m_tdata[INDEX_W +: COORD_W]));
                if (m_tdata[INDEX_W+COORD_W +: COORD_W] !== want.y)
                    note_mismatch("winner_y", 64'(want.y),
                                  64'(m_tdata[INDEX_W+COORD_W +: COORD_W]));
                if (m_tdata[M_DATA_W-1:INDEX_W+2*COORD_W] !== '0)
                    note_mismatch("padding", 64'd0,
                                  64'(m_tdata[M_DATA_W-1:INDEX_W+2*COORD_W]));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                idle_cycles++;
            end
        end
    end

    initial begin
        int                 sent;
        int                 len;
        int                 style;
        logic [COORD_W-1:0] hub_x;
        logic [COORD_W-1:0] hub_y;
        logic [AREA_W-1:0]  area;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        int                 frame_no;

        // first frame, one box at the origin with no area
        add_box('0, '0, '0, 1'b1, 1'b0);
        // far corner against the origin, both full area
        add_box(AREA_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
        add_box(AREA_MAX, '0, '0, 1'b1, 1'b0);
        // equal scores keep the earlier box
        add_box(24'd1000, 16'h1234, 16'h4321, 1'b0, 1'b0);
        add_box(24'd1000, 16'h1234, 16'h4321, 1'b1, 1'b0);
        // negative scores, the nearer corner box beats the farther one, then a nearer box wins
        add_box('0, COORD_MAX, '0, 1'b0, 1'b0);
        add_box('0, '0, COORD_MAX, 1'b0, 1'b0);
        add_box(24'd1, 16'h5555, 16'haaaa, 1'b0, 1'b0);
        add_box('0, 16'haaaa, 16'h5555, 1'b1, 1'b0);
        // small area near the last target beats larger area far away, then a full-area box wins
        add_box(24'd100, COORD_MAX, '0, 1'b0, 1'b1);
        add_box(24'd90, 16'haaaa, 16'h5556, 1'b0, 1'b0);
        add_box(AREA_MAX, 16'hffff, 16'hffff, 1'b1, 1'b0);

        sent     = 0;
        frame_no = 0;
        while (sent < RANDOM_BOXES) begin
            style = $urandom_range(0, 99);
            if (style < 2) len = $urandom_range(FRAME_CAP + 1, FRAME_CAP + 8);
            else if (style < 4) len = FRAME_CAP;
            else if (style < 20) len = 1;
            else len = $urandom_range(2, 8);
            hub_x = COORD_W'($urandom);
            hub_y = COORD_W'($urandom);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 7))
                    0, 1:    area = AREA_W'($urandom);
                    2:       area = AREA_W'($urandom_range(0, 15));
                    default: area = AREA_W'($urandom_range(0, 40000));
                endcase
                if ($urandom_range(0, 1) == 0) begin
                    cx = COORD_W'($urandom);
                    cy = COORD_W'($urandom);
                end else begin
                    cx = hub_x + COORD_W'($urandom_range(0, 2047));
                    cy = hub_y + COORD_W'($urandom_range(0, 2047));
                end
                // late boxes in a full or overfull frame
                if (len >= FRAME_CAP && i >= FRAME_CAP - 1 && $urandom_range(0, 1) == 0)
                    area = AREA_MAX;
                if (i > 0 && $urandom_range(0, 7) == 0) begin
                    area = box_q[box_q.size()-1].area;
                    cx   = box_q[box_q.size()-1].cx;
                    cy   = box_q[box_q.size()-1].cy;
                end
                add_box(area, cx, cy, i == len - 1, i == 0 && frame_no % 25 == 24);
            end
            sent += len;
            frame_no++;
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (box_q.size() > 0 || s_tvalid) @(posedge aclk);
        while (picks_q.size() > 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
